FILE: hdl/vtpd_pkg.sv
`default_nettype none
package vtpd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_REGS = 8;
	localparam int REG_SEL_W = $clog2(NUM_REGS);
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 64;
	localparam int DW = 32;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 2;
	localparam int VW = SW - FRAC_BITS + 1;
	localparam int QB = DW + 1;
	localparam int CW = VW + QB;

	localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;
	localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

	localparam logic CMD_POINT = 1'b0;
	localparam logic CMD_DIR = 1'b1;

	typedef struct packed {
		logic dir;
		logic fault;
		logic [2:0][DW-1:0] dres;
		logic [DW-1:0] wc;
		logic sat;
	} side_t;

	typedef struct packed {
		logic valid;
		side_t side;
		logic [2:0] neg;
		logic [2:0][VW-1:0] num;
		logic [VW-1:0] den;
	} div_in_t;

	typedef struct packed {
		logic valid;
		side_t side;
		logic [2:0] neg;
		logic [2:0] ovf;
		logic [2:0][QB-1:0] q;
	} div_out_t;

	// {sat, value}
	function automatic logic [DW:0] sat32(input logic signed [VW-1:0] v);
		logic [DW:0] r;
		if (v > $signed({{(VW-DW){1'b0}}, POS_MAX})) begin
			r = {1'b1, POS_MAX};
		end else if (v < $signed({{(VW-DW){1'b1}}, NEG_MIN})) begin
			r = {1'b1, NEG_MIN};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/vtpd_div.sv
`default_nettype none
module vtpd_div import vtpd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire div_in_t din,
	output div_out_t dout
);

	typedef struct packed {
		side_t side;
		logic [2:0] neg;
		logic [2:0] ovf;
		logic [2:0][CW-1:0] rem;
		logic [2:0][QB-1:0] q;
		logic [CW-1:0] den;
	} dstage_t;

	dstage_t div_s [QB+1];
	logic valid_s [QB+1];

	// first stage: scale numerator and catch quotients too big to represent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].side <= din.side;
			div_s[0].neg <= din.neg;
			div_s[0].den <= CW'(din.den);
			for (int c = 0; c < 3; c++) begin
				div_s[0].rem[c] <= CW'(din.num[c]) << FRAC_BITS;
				div_s[0].ovf[c] <= (CW'(din.num[c]) << FRAC_BITS) >= (CW'(din.den) << QB);
				div_s[0].q[c] <= '0;
			end
		end
	end

	// one quotient bit per stage, msb first
	for (genvar st = 1; st <= QB; st++) begin : g_stage
		localparam int B = QB - st;
		dstage_t nxt;

		always_comb begin
			nxt = div_s[st-1];
			for (int c = 0; c < 3; c++) begin
				if (div_s[st-1].rem[c] >= (div_s[st-1].den << B)) begin
					nxt.rem[c] = div_s[st-1].rem[c] - (div_s[st-1].den << B);
					nxt.q[c][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[st] <= 1'b0;
			end else if (en) begin
				valid_s[st] <= valid_s[st-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[st] <= nxt;
			end
		end
	end

	assign dout.valid = valid_s[QB];
	assign dout.side = div_s[QB].side;
	assign dout.neg = div_s[QB].neg;
	assign dout.ovf = div_s[QB].ovf;
	assign dout.q = div_s[QB].q;

endmodule
`default_nettype wire

FILE: hdl/vertex_transform_perspective_divide_unit.sv
// stage order: products, sums, translation, signs, divider, output register
// throughput: one beat per cycle; the whole pipeline holds while an output beat waits
// the latency is mostly the 34-stage restoring divider: scaling, then a bit per stage
// reset: clears all valid bits and loads the identity matrix
`default_nettype none
module vertex_transform_perspective_divide_unit import vtpd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [3*DW-1:0] s_tdata, // x_in, y_in, z_in
	input wire logic [0:0] s_tuser, // cmd
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [4*DW-1:0] m_tdata, // x_out, y_out, z_out, w_out
	output logic [1:0] m_tuser, // divide_fault, saturated
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic en;
	logic [CFG_DATA_W-1:0] regs_q [NUM_REGS];
	logic signed [DW-1:0] m [4][4];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
			regs_q[0] <= {{DW{1'b0}}, ONE};
			regs_q[2] <= {ONE, {DW{1'b0}}};
			regs_q[5] <= {{DW{1'b0}}, ONE};
			regs_q[7] <= {ONE, {DW{1'b0}}};
		end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			regs_q[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				m[r][c] = regs_q[r*2 + c/2][(c%2)*DW +: DW];
			end
		end
	end

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: products
	logic valid_s1, dir_s1;
	logic signed [PW-1:0] prod_s1 [4][3];
	logic signed [DW-1:0] xin [3];

	always_comb begin
		for (int r = 0; r < 3; r++) xin[r] = s_tdata[r*DW +: DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s1 <= s_tuser[0];
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 3; r++) begin
					prod_s1[c][r] <= PW'(xin[r]) * PW'(m[r][c]);
				end
			end
		end
	end

	// stage 2: column sums
	logic valid_s2, dir_s2;
	logic signed [SW-1:0] sum_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s2 <= dir_s1;
			for (int c = 0; c < 4; c++) begin
				sum_s2[c] <= SW'(prod_s1[c][0]) + SW'(prod_s1[c][1]) + SW'(prod_s1[c][2]);
			end
		end
	end

	// stage 3: floor to fraction bits, add translation row (not to x, y, z in direction mode)
	logic valid_s3, dir_s3;
	logic signed [VW-1:0] v_s3 [4];
	logic signed [SW-1:0] shifted [4];

	always_comb begin
		for (int c = 0; c < 4; c++) shifted[c] = sum_s2[c] >>> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s3 <= dir_s2;
			for (int c = 0; c < 4; c++) begin
				if (dir_s2 == CMD_DIR && c < 3) begin
					v_s3[c] <= VW'(shifted[c]);
				end else begin
					v_s3[c] <= VW'(shifted[c]) + VW'(m[3][c]);
				end
			end
		end
	end

	// stage 4: signs, magnitudes, clamps for direction mode and w
	logic valid_s4;
	side_t side_s4;
	logic [2:0] neg_s4;
	logic [2:0][VW-1:0] num_s4;
	logic [VW-1:0] den_s4;
	logic [DW:0] sres [4];
	logic [VW-1:0] mag [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sres[c] = sat32(v_s3[c]);
			mag[c] = v_s3[c][VW-1] ? VW'(-v_s3[c]) : VW'(v_s3[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.dir <= dir_s3;
			side_s4.fault <= (dir_s3 == CMD_POINT) && (v_s3[3] == '0);
			for (int c = 0; c < 3; c++) begin
				side_s4.dres[c] <= sres[c][DW-1:0];
				neg_s4[c] <= v_s3[c][VW-1] ^ v_s3[3][VW-1];
				num_s4[c] <= mag[c];
			end
			side_s4.wc <= sres[3][DW-1:0];
			side_s4.sat <= (dir_s3 == CMD_DIR) ? (sres[0][DW] | sres[1][DW] | sres[2][DW])
				: sres[3][DW];
			den_s4 <= mag[3];
		end
	end

	div_in_t din;
	div_out_t dout;

	assign din.valid = valid_s4;
	assign din.side = side_s4;
	assign din.neg = neg_s4;
	assign din.num = num_s4;
	assign din.den = den_s4;

	vtpd_div u_div (
		.clk (clk),
		.arst_n (arst_n),
		.en (en),
		.din (din),
		.dout (dout)
	);

	// output stage: sign and clamp the quotients, select point, direction or fault result
	logic [DW-1:0] qres [3];
	logic [2:0] qsat;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (dout.ovf[c]) begin
				qres[c] = dout.neg[c] ? NEG_MIN : POS_MAX;
				qsat[c] = 1'b1;
			end else if (dout.neg[c]) begin
				qsat[c] = dout.q[c] > QB'(NEG_MIN);
				qres[c] = qsat[c] ? NEG_MIN : DW'(-dout.q[c]);
			end else begin
				qsat[c] = dout.q[c] > QB'(POS_MAX);
				qres[c] = qsat[c] ? POS_MAX : dout.q[c][DW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dout.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dout.side.dir == CMD_DIR) begin
				m_tdata <= {{DW{1'b0}}, dout.side.dres[2], dout.side.dres[1],
					dout.side.dres[0]};
				m_tuser <= {dout.side.sat, 1'b0};
			end else if (dout.side.fault) begin
				m_tdata <= '0;
				m_tuser <= 2'b01;
			end else begin
				m_tdata <= {dout.side.wc, qres[2], qres[1], qres[0]};
				m_tuser <= {dout.side.sat | (|qsat), 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

FILE: verif/vertex_transform_perspective_divide_unit_tb.sv
`default_nettype none
module vertex_transform_perspective_divide_unit_tb;
	import vtpd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PIPE_DRAIN = 60;
	localparam int REG_ROW0_COLS01 = 0;
	localparam int REG_ROW0_COLS23 = 1;
	localparam int REG_ROW1_COLS01 = 2;
	localparam int REG_ROW1_COLS23 = 3;
	localparam int REG_ROW2_COLS01 = 4;
	localparam int REG_ROW2_COLS23 = 5;
	localparam int REG_ROW3_COLS01 = 6;
	localparam int REG_ROW3_COLS23 = 7;
	localparam int REG_BEYOND = NUM_REGS;

	typedef struct {
		logic signed [DW-1:0] x, y, z, w;
		logic fault;
		logic sat;
	} vertex_res_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [3*DW-1:0] s_tdata; // x_in, y_in, z_in
	logic [0:0] s_tuser; // cmd
	logic m_tvalid, m_tready;
	logic [4*DW-1:0] m_tdata; // x_out, y_out, z_out, w_out
	logic [1:0] m_tuser; // divide_fault, saturated
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic signed [DW-1:0] matrix [4][4];
	vertex_res_t pending_vertices [$];
	int idle_pct, stall_pct, hold_cycles, cycle_count;
	bit failed;

	vertex_transform_perspective_divide_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [67:0] column_dot(int c, logic signed [DW-1:0] x,
			logic signed [DW-1:0] y, logic signed [DW-1:0] z);
		logic signed [67:0] a, b, d, ma, mb, md;
		a = x; b = y; d = z;
		ma = matrix[0][c]; mb = matrix[1][c]; md = matrix[2][c];
		return (a * ma + b * mb + d * md) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [DW-1:0] clamp_q(logic signed [127:0] v, inout logic sat);
		if (v > 128'sh7FFFFFFF) begin
			sat = 1'b1;
			return POS_MAX;
		end
		if (v < -128'sh80000000) begin
			sat = 1'b1;
			return NEG_MIN;
		end
		return v[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] persp_div(logic signed [127:0] n,
			logic signed [127:0] d, inout logic sat);
		logic [127:0] un, ud, mag;
		logic signed [127:0] q;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		mag = (un << FRAC_BITS) / ud;
		q = ((n < 0) != (d < 0)) ? -$signed(mag) : $signed(mag);
		return clamp_q(q, sat);
	endfunction

	function automatic vertex_res_t transform_vertex(logic cmd, logic signed [DW-1:0] x,
			logic signed [DW-1:0] y, logic signed [DW-1:0] z);
		vertex_res_t r;
		logic signed [127:0] w, n;
		logic sat;
		sat = 1'b0;
		r.fault = 1'b0;
		if (cmd == CMD_DIR) begin
			r.x = clamp_q(column_dot(0, x, y, z), sat);
			r.y = clamp_q(column_dot(1, x, y, z), sat);
			r.z = clamp_q(column_dot(2, x, y, z), sat);
			r.w = '0;
		end else begin
			w = column_dot(3, x, y, z);
			w = w + matrix[3][3];
			if (w == 0) begin
				r.x = '0; r.y = '0; r.z = '0; r.w = '0;
				r.fault = 1'b1;
			end else begin
				n = column_dot(0, x, y, z); n = n + matrix[3][0];
				r.x = persp_div(n, w, sat);
				n = column_dot(1, x, y, z); n = n + matrix[3][1];
				r.y = persp_div(n, w, sat);
				n = column_dot(2, x, y, z); n = n + matrix[3][2];
				r.z = persp_div(n, w, sat);
				r.w = clamp_q(w, sat);
			end
		end
		r.sat = sat;
		return r;
	endfunction

	// predict on each accepted input beat, track register writes
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			pending_vertices.push_back(transform_vertex(s_tuser[0], s_tdata[DW-1:0],
				s_tdata[2*DW-1:DW], s_tdata[3*DW-1:2*DW]));
		if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) begin
			matrix[cfg_index >> 1][(cfg_index & 1) * 2] = cfg_data[DW-1:0];
			matrix[cfg_index >> 1][(cfg_index & 1) * 2 + 1] = cfg_data[2*DW-1:DW];
		end
	end

	// result checker
	always @(posedge clk) begin
		vertex_res_t e;
		if (m_tvalid && m_tready) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t: unexpected output beat %h/%b", $time, m_tdata, m_tuser);
				failed = 1'b1;
			end else begin
				e = pending_vertices.pop_front();
				if (m_tdata !== {e.w, e.z, e.y, e.x} || m_tuser !== {e.sat, e.fault}) begin
					$display("%0t: expected x %h y %h z %h w %h fault %b sat %b", $time,
						e.x, e.y, e.z, e.w, e.fault, e.sat);
					$display("%0t: actual   x %h y %h z %h w %h fault %b sat %b", $time,
						m_tdata[DW-1:0], m_tdata[2*DW-1:DW], m_tdata[3*DW-1:2*DW],
						m_tdata[4*DW-1:3*DW], m_tuser[0], m_tuser[1]);
					failed = 1'b1;
				end
			end
		end
	end

	// receiver, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= $urandom_range(99) >= stall_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_vertex(logic cmd, logic [DW-1:0] x, logic [DW-1:0] y, logic [DW-1:0] z);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_entries(logic signed [DW-1:0] m [4][4]);
		for (int r = 0; r < 4; r++)
			for (int h = 0; h < 2; h++)
				write_reg(r * 2 + h, {m[r][h * 2 + 1], m[r][h * 2]});
	endtask

	function automatic logic [DW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(3) == 0 ? NEG_MIN : POS_MAX;
			default: return DW'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
		endcase
	endfunction

	function automatic logic [DW-1:0] rand_entry();
		if ($urandom_range(9) == 0)
			return $urandom;
		return DW'($signed($urandom_range(8 * 65536)) - 4 * 65536);
	endfunction

	task automatic load_random_matrix();
		logic signed [DW-1:0] m [4][4];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				m[r][c] = rand_entry();
		if ($urandom_range(1)) begin
			m[0][3] = '0; m[1][3] = '0; m[2][3] = '0;
			m[3][3] = $urandom_range(3) == 0 ? 32'sd1 : 32'(ONE);
		end
		load_entries(m);
	endtask

	task automatic test_identity_extremes();
		send_vertex(CMD_POINT, ONE, ONE << 1, ONE << 2);
		send_vertex(CMD_DIR, ONE, ONE << 1, ONE << 2);
		send_vertex(CMD_POINT, POS_MAX, NEG_MIN, '0);
		send_vertex(CMD_DIR, NEG_MIN, POS_MAX, '1);
		send_vertex(CMD_POINT, '1, '1, '1);
		drain();
	endtask

	task automatic test_register_writes();
		logic signed [DW-1:0] m [4][4];
		// out-of-range index must leave the matrix alone
		write_reg(REG_BEYOND, '1);
		write_reg(CFG_IDX_W'('1), '1);
		send_vertex(CMD_POINT, ONE, ONE, ONE);
		drain();
		// all-zero matrix: point mode w is zero
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				m[r][c] = '0;
		load_entries(m);
		send_vertex(CMD_POINT, ONE, POS_MAX, NEG_MIN);
		send_vertex(CMD_DIR, ONE, POS_MAX, NEG_MIN);
		drain();
		// zero w by cancellation, and tiny w giving a huge quotient
		write_reg(REG_ROW0_COLS23, {32'(ONE), 32'd0});
		write_reg(REG_ROW3_COLS23, {-32'(ONE), 32'd0});
		write_reg(REG_ROW3_COLS01, {32'(ONE), 32'(ONE)});
		send_vertex(CMD_POINT, ONE, ONE, ONE);
		send_vertex(CMD_POINT, ONE + 1, ONE, ONE);
		send_vertex(CMD_POINT, ONE - 1, POS_MAX, NEG_MIN);
		drain();
		// extreme entries in every register but row 0, columns 2 and 3
		write_reg(REG_ROW0_COLS01, {POS_MAX, NEG_MIN});
		write_reg(REG_ROW1_COLS01, {NEG_MIN, POS_MAX});
		write_reg(REG_ROW1_COLS23, {POS_MAX, NEG_MIN});
		write_reg(REG_ROW2_COLS01, '1);
		write_reg(REG_ROW2_COLS23, {NEG_MIN, NEG_MIN});
		write_reg(REG_ROW3_COLS01, {POS_MAX, POS_MAX});
		write_reg(REG_ROW3_COLS23, {32'sd1, NEG_MIN});
		send_vertex(CMD_POINT, POS_MAX, POS_MAX, POS_MAX);
		send_vertex(CMD_POINT, NEG_MIN, NEG_MIN, NEG_MIN);
		send_vertex(CMD_DIR, POS_MAX, NEG_MIN, POS_MAX);
		send_vertex(CMD_DIR, NEG_MIN, NEG_MIN, NEG_MIN);
		send_vertex(CMD_POINT, 32'sd1, -32'sd1, 32'sd0);
		drain();
	endtask

	task automatic test_random_stream(int n_items, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n_items; i++) begin
			if (i % 120 == 0) begin
				drain();
				load_random_matrix();
			end
			send_vertex($urandom_range(3) == 0 ? CMD_DIR : CMD_POINT,
				rand_coord(), rand_coord(), rand_coord());
		end
		drain();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 400;
		for (int i = 0; i < 100; i++)
			send_vertex($urandom_range(1) != 0 ? CMD_DIR : CMD_POINT,
				rand_coord(), rand_coord(), rand_coord());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		cycle_count = 0;
		failed = 1'b0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				matrix[r][c] = (r == c) ? ONE : '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_identity_extremes();
		test_register_writes();
		test_random_stream(450, 0, 0);
		test_random_stream(450, 47, 0);
		test_random_stream(450, 0, 47);
		test_random_stream(450, 26, 26);
		test_backpressure();
		if (!failed) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: vertex_transform_perspective_divide_unit.f
hdl/vtpd_pkg.sv
hdl/vtpd_div.sv
hdl/vertex_transform_perspective_divide_unit.sv
verif/vertex_transform_perspective_divide_unit_tb.sv
